// ----- rtl/vau_pkg.sv -----
`timescale 1ns / 1ps
package vau_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = FRAC_BITS + 1;
    // multiply, sum, saturate/normalize, root cells, divide cells, output
    localparam int LATENCY    = 3 + SQRT_STEPS + DIV_STEPS + 1;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_SUB    = 3'd1;
    localparam logic [2:0] OP_SCALE  = 3'd2;
    localparam logic [2:0] OP_DOT    = 3'd3;
    localparam logic [2:0] OP_CROSS  = 3'd4;
    localparam logic [2:0] OP_LENGTH = 3'd5;
    localparam logic [2:0] OP_NORM   = 3'd6;

    // Item flowing down the cell chain
    typedef struct packed {
        logic             valid;
        logic [2:0]       op;
        logic [2:0]       neg;
        logic [2:0][31:0] r;
        logic [31:0]      scalar;
        logic             ovf;
        logic             zl;
    } item_t;

    // Square root working state
    typedef struct packed {
        logic [63:0] rad;
        logic [33:0] rem;
        logic [31:0] root;
    } sq_t;

    // Divider working state
    typedef struct packed {
        logic [31:0]      divisor;
        logic [2:0][31:0] rem;
    } dv_t;

endpackage

// ----- rtl/vau_front.sv -----
`timescale 1ns / 1ps
module vau_front
    import vau_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [2:0]         opcode,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    input  logic signed [31:0] scale_factor,
    output item_t              itm,
    output sq_t                sq
);

    localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
    localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

    function automatic logic [32:0] sat32(input logic signed [65:0] v);
        if (v > SAT_HI) begin
            return {1'b1, 32'h7FFF_FFFF};
        end
        if (v < SAT_LO) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, v[31:0]};
    endfunction

    // stage 1: products, or the sums and differences for add and subtract
    logic signed [31:0] la [3];
    logic signed [31:0] lb [3];
    logic signed [31:0] ma [6];
    logic signed [31:0] mb [6];
    logic signed [32:0] sum33;
    logic signed [63:0] p_next [6];
    logic signed [63:0] p_reg  [6];
    logic signed [31:0] a1_reg [3];
    logic [2:0]         op1_reg;
    logic               v1_reg;

    always_comb
    begin
        la[0] = a_x; la[1] = a_y; la[2] = a_z;
        lb[0] = b_x; lb[1] = b_y; lb[2] = b_z;
        for (int i = 0; i < 6; i++)
        begin
            ma[i] = '0;
            mb[i] = '0;
        end
        unique case (opcode)
            OP_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ma[i] = la[i];
                    mb[i] = scale_factor;
                end
            end
            OP_DOT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ma[i] = la[i];
                    mb[i] = lb[i];
                end
            end
            OP_CROSS:
            begin
                ma[0] = a_y; mb[0] = b_z;
                ma[1] = a_z; mb[1] = b_y;
                ma[2] = a_z; mb[2] = b_x;
                ma[3] = a_x; mb[3] = b_z;
                ma[4] = a_x; mb[4] = b_y;
                ma[5] = a_y; mb[5] = b_x;
            end
            OP_LENGTH, OP_NORM:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ma[i] = la[i];
                    mb[i] = la[i];
                end
            end
            default:
            begin
            end
        endcase
        sum33 = '0;
        for (int i = 0; i < 6; i++)
        begin
            p_next[i] = ma[i] * mb[i];
        end
        if (opcode == OP_ADD || opcode == OP_SUB)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (opcode == OP_ADD)
                begin
                    sum33 = {la[i][31], la[i]} + {lb[i][31], lb[i]};
                end
                else
                begin
                    sum33 = {la[i][31], la[i]} - {lb[i][31], lb[i]};
                end
                p_next[i] = {{31{sum33[32]}}, sum33};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            op1_reg <= '0;
            for (int i = 0; i < 6; i++)
            begin
                p_reg[i] <= '0;
            end
            for (int i = 0; i < 3; i++)
            begin
                a1_reg[i] <= '0;
            end
        end
        else
        begin
            v1_reg  <= start;
            op1_reg <= opcode;
            for (int i = 0; i < 6; i++)
            begin
                p_reg[i] <= p_next[i];
            end
            for (int i = 0; i < 3; i++)
            begin
                a1_reg[i] <= la[i];
            end
        end
    end

    // stage 2: sums and differences, exact
    logic signed [65:0] ext    [6];
    logic signed [65:0] v_next [3];
    logic signed [65:0] vs_next;
    logic signed [65:0] v_reg  [3];
    logic signed [65:0] vs_reg;
    logic signed [31:0] a2_reg [3];
    logic [2:0]         op2_reg;
    logic               v2_reg;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            ext[i] = {{2{p_reg[i][63]}}, p_reg[i]};
        end
        for (int i = 0; i < 3; i++)
        begin
            v_next[i] = ext[i];
        end
        vs_next = ext[0] + ext[1] + ext[2];
        if (op1_reg == OP_CROSS)
        begin
            v_next[0] = ext[0] - ext[1];
            v_next[1] = ext[2] - ext[3];
            v_next[2] = ext[4] - ext[5];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg  <= 1'b0;
            op2_reg <= '0;
            vs_reg  <= '0;
            for (int i = 0; i < 3; i++)
            begin
                v_reg[i]  <= '0;
                a2_reg[i] <= '0;
            end
        end
        else
        begin
            v2_reg  <= v1_reg;
            op2_reg <= op1_reg;
            vs_reg  <= vs_next;
            for (int i = 0; i < 3; i++)
            begin
                v_reg[i]  <= v_next[i];
                a2_reg[i] <= a1_reg[i];
            end
        end
    end

    // stage 3: shift, saturate, normalize the sum of squares
    item_t              itm_next;
    sq_t                sq_next;
    item_t              itm_reg;
    sq_t                sq_reg;
    logic [32:0]        sres;
    logic signed [65:0] shv;
    logic [63:0]        qn;
    logic [4:0]         half;
    logic [31:0]        mag;
    logic [63:0]        wide;

    always_comb
    begin
        itm_next        = '0;
        itm_next.valid  = v2_reg;
        itm_next.op     = op2_reg;
        sres            = '0;
        shv             = '0;
        mag             = '0;
        wide            = '0;
        qn              = vs_reg[63:0];
        half            = '0;
        if (qn[63:32] == '0) begin qn = {qn[31:0], 32'b0}; half = half + 5'd16; end
        if (qn[63:48] == '0) begin qn = {qn[47:0], 16'b0}; half = half + 5'd8;  end
        if (qn[63:56] == '0) begin qn = {qn[55:0], 8'b0};  half = half + 5'd4;  end
        if (qn[63:60] == '0) begin qn = {qn[59:0], 4'b0};  half = half + 5'd2;  end
        if (qn[63:62] == '0) begin qn = {qn[61:0], 2'b0};  half = half + 5'd1;  end
        sq_next.rad  = (op2_reg == OP_NORM) ? qn : vs_reg[63:0];
        sq_next.rem  = '0;
        sq_next.root = '0;
        unique case (op2_reg)
            OP_ADD, OP_SUB:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sres          = sat32(v_reg[i]);
                    itm_next.r[i] = sres[31:0];
                    itm_next.ovf  = itm_next.ovf | sres[32];
                end
            end
            OP_SCALE, OP_CROSS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    shv           = v_reg[i] >>> FRAC_BITS;
                    sres          = sat32(shv);
                    itm_next.r[i] = sres[31:0];
                    itm_next.ovf  = itm_next.ovf | sres[32];
                end
            end
            OP_DOT:
            begin
                shv             = vs_reg >>> FRAC_BITS;
                sres            = sat32(shv);
                itm_next.scalar = sres[31:0];
                itm_next.ovf    = sres[32];
            end
            OP_NORM:
            begin
                if (vs_reg == '0)
                begin
                    itm_next.zl = 1'b1;
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag             = a2_reg[i][31] ? (32'd0 - a2_reg[i]) : a2_reg[i];
                        wide            = {32'b0, mag} << half;
                        itm_next.r[i]   = wide[31:0];
                        itm_next.neg[i] = a2_reg[i][31];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            itm_reg <= '0;
            sq_reg  <= '0;
        end
        else
        begin
            itm_reg <= itm_next;
            sq_reg  <= sq_next;
        end
    end

    assign itm = itm_reg;
    assign sq  = sq_reg;

endmodule

// ----- rtl/vau_sqrt_cell.sv -----
`timescale 1ns / 1ps
module vau_sqrt_cell
    import vau_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  item_t itm_in,
    input  sq_t   sq_in,
    output item_t itm_out,
    output sq_t   sq_out
);

    logic [35:0] tmp;
    logic [35:0] trial;
    logic [35:0] diff;
    sq_t         sq_next;
    item_t       itm_reg;
    sq_t         sq_reg;

    // one root digit: bring down two radicand bits, try root*4+1
    always_comb
    begin
        tmp         = {sq_in.rem, sq_in.rad[63:62]};
        trial       = {2'b00, sq_in.root, 2'b01};
        diff        = tmp - trial;
        sq_next.rad = {sq_in.rad[61:0], 2'b00};
        if (tmp >= trial)
        begin
            sq_next.rem  = diff[33:0];
            sq_next.root = {sq_in.root[30:0], 1'b1};
        end
        else
        begin
            sq_next.rem  = tmp[33:0];
            sq_next.root = {sq_in.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            itm_reg <= '0;
            sq_reg  <= '0;
        end
        else
        begin
            itm_reg <= itm_in;
            sq_reg  <= sq_next;
        end
    end

    assign itm_out = itm_reg;
    assign sq_out  = sq_reg;

endmodule

// ----- rtl/vau_div_cell.sv -----
`timescale 1ns / 1ps
module vau_div_cell
    import vau_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  item_t itm_in,
    input  dv_t   dv_in,
    output item_t itm_out,
    output dv_t   dv_out
);

    logic [32:0] tmp;
    logic [32:0] dsr;
    logic [32:0] diff;
    logic        act;
    item_t       itm_next;
    dv_t         dv_next;
    item_t       itm_reg;
    dv_t         dv_reg;

    // one quotient bit per lane; dividend bits shift out of r, quotient bits in
    always_comb
    begin
        itm_next = itm_in;
        dv_next  = dv_in;
        act      = (itm_in.op == OP_NORM) && !itm_in.zl;
        dsr      = {1'b0, dv_in.divisor};
        tmp      = '0;
        diff     = '0;
        for (int i = 0; i < 3; i++)
        begin
            tmp  = {dv_in.rem[i], itm_in.r[i][31]};
            diff = tmp - dsr;
            if (act)
            begin
                if (tmp >= dsr)
                begin
                    dv_next.rem[i]  = diff[31:0];
                    itm_next.r[i]   = {itm_in.r[i][30:0], 1'b1};
                end
                else
                begin
                    dv_next.rem[i]  = tmp[31:0];
                    itm_next.r[i]   = {itm_in.r[i][30:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            itm_reg <= '0;
            dv_reg  <= '0;
        end
        else
        begin
            itm_reg <= itm_next;
            dv_reg  <= dv_next;
        end
    end

    assign itm_out = itm_reg;
    assign dv_out  = dv_reg;

endmodule

// ----- rtl/vector3_arithmetic_unit.sv -----
`timescale 1ns / 1ps
// Three-component vector unit in signed fixed point (FRAC_BITS fraction bits,
// Q16.16 by default). It takes one item per clock: busy is never raised, so
// start may be held high every cycle. Each item gives one result (Q16.16 for
// the default FRAC_BITS), marked by a one-cycle done strobe; results leave
// in the order items came in and the receiver must take them in that cycle,
// since it cannot stall the unit. The latency is set by the chain of 32
// square-root cells (two radicand bits per cell) followed by FRAC_BITS + 1
// restoring-divide cells (one quotient bit per cell, three lanes side by
// side). Every operation travels the whole chain, so add and dot take as
// long as normalize. Products and sums are exact, shifted back with floor,
// and saturate with overflow set; normalize of a zero vector gives a zero
// vector with zero_length set.
module vector3_arithmetic_unit
    import vau_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         opcode,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    input  logic signed [31:0] scale_factor,
    output logic               done,
    output logic signed [31:0] r_x,
    output logic signed [31:0] r_y,
    output logic signed [31:0] r_z,
    output logic signed [31:0] r_scalar,
    output logic               overflow,
    output logic               zero_length
);

    // The pipeline never stalls: accept every cycle.
    assign busy = 1'b0;

    item_t sq_itm [SQRT_STEPS + 1];
    sq_t   sq_st  [SQRT_STEPS + 1];
    item_t dv_itm [DIV_STEPS + 1];
    dv_t   dv_st  [DIV_STEPS + 1];

    // Multiply, sum, then shift and saturate; normalize radicand for the root.
    vau_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .opcode       (opcode),
        .a_x          (a_x),
        .a_y          (a_y),
        .a_z          (a_z),
        .b_x          (b_x),
        .b_y          (b_y),
        .b_z          (b_z),
        .scale_factor (scale_factor),
        .itm          (sq_itm[0]),
        .sq           (sq_st[0])
    );

    // Square-root chain: every cell adds one root bit.
    for (genvar g = 0; g < SQRT_STEPS; g++)
    begin : g_sqrt
        vau_sqrt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .itm_in  (sq_itm[g]),
            .sq_in   (sq_st[g]),
            .itm_out (sq_itm[g + 1]),
            .sq_out  (sq_st[g + 1])
        );
    end

    // Hand-off: finish length, and load the dividers for normalize.
    logic [31:0] root;
    item_t       dv_itm0;
    dv_t         dv_st0;

    always_comb
    begin
        dv_itm0          = sq_itm[SQRT_STEPS];
        root             = sq_st[SQRT_STEPS].root;
        dv_st0.divisor   = root;
        dv_st0.rem       = '0;
        if (sq_itm[SQRT_STEPS].op == OP_LENGTH)
        begin
            dv_itm0.ovf    = root[31];
            dv_itm0.scalar = root[31] ? 32'h7FFF_FFFF : root;
        end
        if (sq_itm[SQRT_STEPS].op == OP_NORM && !sq_itm[SQRT_STEPS].zl)
        begin
            // Start the division with the top 31 dividend bits as remainder;
            // park the last dividend bit at the top of r to be shifted in.
            for (int i = 0; i < 3; i++)
            begin
                dv_st0.rem[i] = {1'b0, sq_itm[SQRT_STEPS].r[i][31:1]};
                dv_itm0.r[i]  = {sq_itm[SQRT_STEPS].r[i][0], 31'b0};
            end
        end
    end

    assign dv_itm[0] = dv_itm0;
    assign dv_st[0]  = dv_st0;

    // Divide chain: one quotient bit per cell for all three components.
    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_div
        vau_div_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .itm_in  (dv_itm[g]),
            .dv_in   (dv_st[g]),
            .itm_out (dv_itm[g + 1]),
            .dv_out  (dv_st[g + 1])
        );
    end

    // Output register: apply the signs of the normalized quotient.
    item_t            fin;
    logic [2:0][31:0] r_next;
    logic             done_reg;
    logic [2:0][31:0] r_reg;
    logic [31:0]      scalar_reg;
    logic             ovf_reg;
    logic             zl_reg;

    always_comb
    begin
        fin    = dv_itm[DIV_STEPS];
        r_next = fin.r;
        if (fin.op == OP_NORM)
        begin
            for (int i = 0; i < 3; i++)
            begin
                r_next[i] = fin.neg[i] ? (32'd0 - fin.r[i]) : fin.r[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            r_reg      <= '0;
            scalar_reg <= '0;
            ovf_reg    <= 1'b0;
            zl_reg     <= 1'b0;
        end
        else
        begin
            done_reg   <= fin.valid;
            r_reg      <= r_next;
            scalar_reg <= fin.scalar;
            ovf_reg    <= fin.ovf;
            zl_reg     <= fin.zl;
        end
    end

    assign done        = done_reg;
    assign r_x         = r_reg[0];
    assign r_y         = r_reg[1];
    assign r_z         = r_reg[2];
    assign r_scalar    = scalar_reg;
    assign overflow    = ovf_reg;
    assign zero_length = zl_reg;

`ifndef SYNTH
    a_start_done : assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("item accepted without a result after the fixed latency");

    a_done_start : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result strobe without a matching accepted item");

    a_zero_len : assert property (@(posedge clk) disable iff (!rst_n)
        (done && zero_length) |->
            (r_x == 32'sd0 && r_y == 32'sd0 && r_z == 32'sd0
             && r_scalar == 32'sd0 && !overflow))
        else $error("zero-length result carries nonzero data");
`endif

endmodule

// ----- test/vector3_arithmetic_unit_tb.sv -----
`timescale 1ns / 1ps
module vector3_arithmetic_unit_tb;
    import vau_pkg::*;

    // Expected outcome of one vector operation
    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] s;
        logic               ovf;
        logic               zl;
    } vec_result_t;

    // One row of the directed table; has_ref marks a typed-in answer
    typedef struct {
        logic [2:0]         op;
        logic signed [31:0] ax, ay, az, bx, by, bz, sf;
        bit                 has_ref;
        vec_result_t        ref_res;
    } vec_row_t;

    localparam int MAX_CYCLES = 200000;
    localparam logic signed [31:0] SMAX = 32'sh7fffffff;
    localparam logic signed [31:0] SMIN = 32'sh80000000;
    localparam logic signed [31:0] ONE  = 32'sh00010000;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         opcode;
    logic signed [31:0] a_x, a_y, a_z, b_x, b_y, b_z, scale_factor;
    logic               done;
    logic signed [31:0] r_x, r_y, r_z, r_scalar;
    logic               overflow;
    logic               zero_length;

    vec_result_t results_due[$];
    int          mismatches;
    int          cycle_count;
    bit          no_idle;

    vector3_arithmetic_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .a_x          (a_x),
        .a_y          (a_y),
        .a_z          (a_z),
        .b_x          (b_x),
        .b_y          (b_y),
        .b_z          (b_z),
        .scale_factor (scale_factor),
        .done         (done),
        .r_x          (r_x),
        .r_y          (r_y),
        .r_z          (r_z),
        .r_scalar     (r_scalar),
        .overflow     (overflow),
        .zero_length  (zero_length)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Clamp a wide value to 32 bits, flagging saturation
    function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
                                                   inout logic ovf);
        if (v > 128'sd2147483647) begin
            ovf = 1'b1;
            return SMAX;
        end
        if (v < -128'sd2147483648) begin
            ovf = 1'b1;
            return SMIN;
        end
        return v[31:0];
    endfunction

    // Integer square root, bit by bit
    function automatic logic [63:0] root64(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Compute the expected result of one item; arithmetic shift is floor
    function automatic vec_result_t vec_predict(input vec_row_t it);
        vec_result_t        o;
        logic signed [127:0] a[3], b[3], p;
        logic [127:0]        q, m, d;
        logic [63:0]         l;
        int                  half;
        o = '{x: 0, y: 0, z: 0, s: 0, ovf: 1'b0, zl: 1'b0};
        a[0] = it.ax; a[1] = it.ay; a[2] = it.az;
        b[0] = it.bx; b[1] = it.by; b[2] = it.bz;
        case (it.op)
            OP_ADD: begin
                o.x = clamp32(a[0] + b[0], o.ovf);
                o.y = clamp32(a[1] + b[1], o.ovf);
                o.z = clamp32(a[2] + b[2], o.ovf);
            end
            OP_SUB: begin
                o.x = clamp32(a[0] - b[0], o.ovf);
                o.y = clamp32(a[1] - b[1], o.ovf);
                o.z = clamp32(a[2] - b[2], o.ovf);
            end
            OP_SCALE: begin
                o.x = clamp32((a[0] * it.sf) >>> FRAC_BITS, o.ovf);
                o.y = clamp32((a[1] * it.sf) >>> FRAC_BITS, o.ovf);
                o.z = clamp32((a[2] * it.sf) >>> FRAC_BITS, o.ovf);
            end
            OP_DOT: begin
                p = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
                o.s = clamp32(p >>> FRAC_BITS, o.ovf);
            end
            OP_CROSS: begin
                o.x = clamp32((a[1] * b[2] - a[2] * b[1]) >>> FRAC_BITS, o.ovf);
                o.y = clamp32((a[2] * b[0] - a[0] * b[2]) >>> FRAC_BITS, o.ovf);
                o.z = clamp32((a[0] * b[1] - a[1] * b[0]) >>> FRAC_BITS, o.ovf);
            end
            OP_LENGTH: begin
                q = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
                l = root64(q[63:0]);
                if (l > 64'd2147483647) begin
                    o.ovf = 1'b1;
                    o.s   = SMAX;
                end else begin
                    o.s = l[31:0];
                end
            end
            OP_NORM: begin
                q = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
                if (q == 0) begin
                    o.zl = 1'b1;
                end else begin
                    half = 0;
                    while (q < (128'd1 << 62)) begin
                        q = q << 2;
                        half++;
                    end
                    l = root64(q[63:0]);
                    for (int i = 0; i < 3; i++) begin
                        m = a[i] < 0 ? -a[i] : a[i];
                        // the shifted magnitude wraps at 64 bits
                        m = ((m << half) << FRAC_BITS) & {64'd0, {64{1'b1}}};
                        d = m / l;
                        p = a[i] < 0 ? -$signed(d) : $signed(d);
                        if (i == 0) o.x = p[31:0];
                        else if (i == 1) o.y = p[31:0];
                        else o.z = p[31:0];
                    end
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    // Check each strobed result against the oldest expectation
    always @(posedge clk) begin
        vec_result_t e;
        if (rst_n && done) begin
            if (results_due.size() == 0) begin
                report_mismatch("unexpected result", r_x, 32'd0);
            end else begin
                e = results_due.pop_front();
                if (r_x !== e.x) report_mismatch("r_x", r_x, e.x);
                if (r_y !== e.y) report_mismatch("r_y", r_y, e.y);
                if (r_z !== e.z) report_mismatch("r_z", r_z, e.z);
                if (r_scalar !== e.s) report_mismatch("r_scalar", r_scalar, e.s);
                if (overflow !== e.ovf)
                    report_mismatch("overflow", {31'b0, overflow}, {31'b0, e.ovf});
                if (zero_length !== e.zl)
                    report_mismatch("zero_length", {31'b0, zero_length}, {31'b0, e.zl});
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    // Present one item, hold it until taken, and queue its expected result
    task automatic send_item(input vec_row_t it);
        vec_result_t e;
        e = it.has_ref ? it.ref_res : vec_predict(it);
        start        <= 1'b1;
        opcode       <= it.op;
        a_x          <= it.ax;
        a_y          <= it.ay;
        a_z          <= it.az;
        b_x          <= it.bx;
        b_y          <= it.by;
        b_z          <= it.bz;
        scale_factor <= it.sf;
        @(posedge clk);
        while (busy) @(posedge clk);
        results_due.push_back(e);
        // insert an idle burst now and then; inside this task start drops only here
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    function automatic logic signed [31:0] rand_val();
        case ($urandom_range(0, 5))
            0: return SMAX;
            1: return SMIN;
            2: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            3: return $signed($urandom_range(0, 32'hffffff)) - 32'sh800000;
            default: return $urandom;
        endcase
    endfunction

    function automatic vec_row_t mk(input logic [2:0] op,
                                    input logic signed [31:0] ax, ay, az, bx, by, bz, sf);
        vec_row_t r;
        r = '{op: op, ax: ax, ay: ay, az: az, bx: bx, by: by, bz: bz, sf: sf,
              has_ref: 1'b0, ref_res: '{0, 0, 0, 0, 1'b0, 1'b0}};
        return r;
    endfunction

    function automatic vec_row_t mk_ref(input vec_row_t r, input vec_result_t e);
        r.has_ref = 1'b1;
        r.ref_res = e;
        return r;
    endfunction

    initial begin
        vec_row_t directed[$];
        vec_row_t it;
        int       wait_cycles;

        mismatches   = 0;
        cycle_count  = 0;
        no_idle      = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        opcode       = OP_ADD;
        a_x = 0; a_y = 0; a_z = 0;
        b_x = 0; b_y = 0; b_z = 0;
        scale_factor = 0;

        // Directed table: answers typed in where obvious
        directed.push_back(mk_ref(mk(OP_ADD, ONE, 2 * ONE, -ONE, ONE, ONE, ONE, 0),
                                  '{2 * ONE, 3 * ONE, 0, 0, 1'b0, 1'b0}));
        directed.push_back(mk_ref(mk(OP_ADD, SMAX, SMIN, 0, 1, -1, 0, 0),
                                  '{SMAX, SMIN, 0, 0, 1'b1, 1'b0}));
        directed.push_back(mk_ref(mk(OP_SUB, SMIN, SMAX, 5, 1, -1, 5, 0),
                                  '{SMIN, SMAX, 0, 0, 1'b1, 1'b0}));
        directed.push_back(mk(OP_SUB, 123, -456, 789, -1, 2, -3, 0));
        directed.push_back(mk_ref(mk(OP_SCALE, ONE, -ONE, 3, 0, 0, 0, 2 * ONE),
                                  '{2 * ONE, -2 * ONE, 6, 0, 1'b0, 1'b0}));
        directed.push_back(mk(OP_SCALE, -1, 1, SMIN, 0, 0, 0, ONE / 2));
        directed.push_back(mk_ref(mk(OP_SCALE, SMAX, SMIN, SMIN, 0, 0, 0, SMIN),
                                  '{SMIN, SMAX, SMAX, 0, 1'b1, 1'b0}));
        directed.push_back(mk_ref(mk(OP_DOT, ONE, ONE, ONE, ONE, 2 * ONE, 3 * ONE, 0),
                                  '{0, 0, 0, 6 * ONE, 1'b0, 1'b0}));
        directed.push_back(mk_ref(mk(OP_DOT, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, 0),
                                  '{0, 0, 0, SMAX, 1'b1, 1'b0}));
        directed.push_back(mk(OP_DOT, SMIN, SMIN, SMIN, SMAX, SMAX, SMAX, 0));
        directed.push_back(mk(OP_DOT, -1, 1, -1, 1, 1, 1, 0));
        directed.push_back(mk_ref(mk(OP_CROSS, ONE, 0, 0, 0, ONE, 0, 0),
                                  '{0, 0, ONE, 0, 1'b0, 1'b0}));
        directed.push_back(mk(OP_CROSS, SMIN, SMAX, SMIN, SMAX, SMIN, SMAX, 0));
        directed.push_back(mk_ref(mk(OP_LENGTH, 3, 4, 0, 0, 0, 0, 0),
                                  '{0, 0, 0, 5, 1'b0, 1'b0}));
        directed.push_back(mk_ref(mk(OP_LENGTH, SMIN, SMIN, SMIN, 0, 0, 0, 0),
                                  '{0, 0, 0, SMAX, 1'b1, 1'b0}));
        directed.push_back(mk(OP_LENGTH, SMAX, 0, 0, 0, 0, 0, 0));
        // zero vector normalized
        directed.push_back(mk_ref(mk(OP_NORM, 0, 0, 0, 1, 1, 1, 1),
                                  '{0, 0, 0, 0, 1'b0, 1'b1}));
        // unit vector normalized gives itself
        directed.push_back(mk_ref(mk(OP_NORM, 0, -ONE, 0, 0, 0, 0, 0),
                                  '{0, -ONE, 0, 0, 1'b0, 1'b0}));
        directed.push_back(mk(OP_NORM, SMIN, SMIN, SMIN, 0, 0, 0, 0));
        directed.push_back(mk(OP_NORM, SMAX, 1, -1, 0, 0, 0, 0));
        directed.push_back(mk(OP_NORM, 1, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk(OP_NORM, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0));
        directed.push_back(mk_ref(mk(OP_UNUSED, SMAX, SMIN, 7, 7, 7, 7, 7),
                                  '{0, 0, 0, 0, 1'b0, 1'b0}));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i]) send_item(directed[i]);

        // Hold off until the pipeline is drained
        start <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);

        for (int n = 0; n < 500; n++) begin
            if (n == 420) no_idle = 1'b1;
            it = mk(3'($urandom_range(0, 7)), rand_val(), rand_val(), rand_val(),
                    rand_val(), rand_val(), rand_val(), rand_val());
            // a share of normalize items on random zero vectors
            if (it.op == OP_NORM && $urandom_range(0, 9) == 0) begin
                it.ax = 0; it.ay = 0; it.az = 0;
            end
            send_item(it);
        end
        start <= 1'b0;

        wait_cycles = 0;
        while (results_due.size() != 0 && wait_cycles < 10 * LATENCY) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (LATENCY + 5) @(posedge clk);

        if (mismatches == 0 && results_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
